### hdl/kmer_count_both_strands_core_defines.svh
// Assertion macros for the checker file of the k-mer counting core.
`ifndef KMER_COUNT_BOTH_STRANDS_CORE_DEFINES_SVH
`define KMER_COUNT_BOTH_STRANDS_CORE_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define KCBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcbs check failed");

// Checks the same relation at every edge, reset included.
`define KCBS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("kcbs check failed during or after reset");

`endif

### hdl/kcbs_pkg.sv
// Package with the constants and types shared by the k-mer counting core.
`timescale 1ns / 1ps
`default_nettype none
package kcbs_pkg;

   localparam int MAX_KMER_DEFAULT   = 8;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam int REQ_DATA_W    = 24;
   localparam int REQ_USER_W    = 2;
   localparam int RSP_DATA_W    = 32;
   localparam int QUERY_BITS    = 16;
   localparam int KMER_LENGTH_W = 4;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [KMER_LENGTH_W-1:0] KMER_LENGTH_RESET = 4'd8;

   localparam logic OPC_ADD  = 1'b0;
   localparam logic OPC_READ = 1'b1;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef enum logic {
      CMD_BUMP,
      CMD_READ
   } cmd_kind_type;

   // The complement of a base: A and T swap, C and G swap.
   function automatic logic [1:0] complement_base(input logic [1:0] b);
      logic [1:0] r;
      case (b)
         BASE_A:  r = BASE_T;
         BASE_C:  r = BASE_G;
         BASE_G:  r = BASE_C;
         default: r = BASE_A;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/kcbs_queue.sv
// Short command queue between the front and back parts of the core.
`timescale 1ns / 1ps
`default_nettype none
module kcbs_queue
   import kcbs_pkg::*;
#(
   parameter int WIDTH = 34
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/kcbs_front.sv
// Front part: takes request words, keeps the base window and queues count and read commands.
`timescale 1ns / 1ps
`default_nettype none
module kcbs_front
   import kcbs_pkg::*;
#(
   parameter int MAX_KMER = MAX_KMER_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [REQ_USER_W-1:0]    req_tuser,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [KMER_LENGTH_W-1:0] csr_data,
   input  wire logic                     clearing,
   input  wire logic                     q_full,
   output logic                          q_push,
   output logic [2*2*MAX_KMER+1:0]       q_data
);

   localparam int IDX_W  = 2 * MAX_KMER;
   localparam int QEXT_W = (IDX_W > QUERY_BITS) ? IDX_W : QUERY_BITS;
   localparam int FILL_W = $clog2(MAX_KMER + 1);

   logic [KMER_LENGTH_W-1:0] kmer_length_ff;
   logic [IDX_W-1:0]         window_ff;
   logic [IDX_W-1:0]         window_in;
   logic [FILL_W-1:0]        fill_ff;
   logic [FILL_W-1:0]        fill_in;
   logic [FILL_W-1:0]        fill_base;

   logic                     accept;
   logic                     opcode;
   logic [1:0]               base;
   logic                     seq_start;
   logic [QUERY_BITS-1:0]    query_kmer;
   logic [QEXT_W-1:0]        query_ext;

   logic [KMER_LENGTH_W-1:0] k_active;
   logic [IDX_W-1:0]         kmask;
   logic [IDX_W-1:0]         fwd;
   logic [IDX_W-1:0]         rc_full;
   logic [IDX_W-1:0]         rc;
   logic [4:0]               rc_shift;
   logic                     enough;
   cmd_kind_type             kind;
   logic                     pal;
   logic [IDX_W-1:0]         addr_a;
   logic [IDX_W-1:0]         addr_b;

   assign opcode     = req_tuser[0];
   assign seq_start  = req_tuser[1];
   assign base       = req_tdata[1:0];
   assign query_kmer = req_tdata[2 +: QUERY_BITS];
   assign query_ext  = QEXT_W'(query_kmer);

   assign req_tready = !q_full && !clearing;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (kmer_length_ff == '0) begin
         k_active = KMER_LENGTH_W'(1);
      end else if (kmer_length_ff > KMER_LENGTH_W'(MAX_KMER)) begin
         k_active = KMER_LENGTH_W'(MAX_KMER);
      end else begin
         k_active = kmer_length_ff;
      end
   end

   assign window_in = IDX_W'({window_ff, base});
   assign fill_base = seq_start ? '0 : fill_ff;
   assign fill_in   = (fill_base < FILL_W'(MAX_KMER)) ? fill_base + 1'b1 : fill_base;
   assign enough    = (KMER_LENGTH_W'(fill_in) >= k_active);

   assign kmask    = ~({IDX_W{1'b1}} << {k_active, 1'b0});
   assign fwd      = window_in & kmask;
   assign rc_shift = {KMER_LENGTH_W'(MAX_KMER) - k_active, 1'b0};

   // The full-width reverse complement places the k-mer in the top digits.
   always_comb begin
      for (int i = 0; i < MAX_KMER; i++) begin
         rc_full[2*i +: 2] = complement_base(fwd[2*(MAX_KMER-1-i) +: 2]);
      end
   end

   assign rc  = rc_full >> rc_shift;
   assign pal = (fwd == rc);

   always_comb begin
      if (opcode == OPC_READ) begin
         kind   = CMD_READ;
         addr_a = query_ext[IDX_W-1:0];
         addr_b = '0;
         q_push = accept;
      end else begin
         kind   = CMD_BUMP;
         addr_a = fwd;
         addr_b = rc;
         q_push = accept && enough;
      end
   end

   assign q_data = {addr_b, addr_a, pal, kind};

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= KMER_LENGTH_RESET;
         window_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            kmer_length_ff <= csr_data;
         end
         if (accept && (opcode == OPC_ADD)) begin
            window_ff <= window_in;
            fill_ff   <= fill_in;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/kcbs_back.sv
// Back part: clears and updates the count memory and returns read results.
`timescale 1ns / 1ps
`default_nettype none
module kcbs_back
   import kcbs_pkg::*;
#(
   parameter int MAX_KMER   = MAX_KMER_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire logic [2*2*MAX_KMER+1:0] q_data,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int IDX_W       = 2 * MAX_KMER;
   localparam int TABLE_DEPTH = 1 << IDX_W;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_FIRST,
      S_SECOND
   } state_type;

   state_type               state_ff;
   logic [IDX_W-1:0]        clr_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   cmd_kind_type            kind_ff;
   logic                    pal_ff;
   logic [IDX_W-1:0]        addr_a_ff;
   logic [IDX_W-1:0]        addr_b_ff;

   logic [COUNT_BITS-1:0]   count_mem_ff [TABLE_DEPTH];
   logic [COUNT_BITS-1:0]   rd_data_ff;

   cmd_kind_type            head_kind;
   logic                    head_pal;
   logic [IDX_W-1:0]        head_a;
   logic [IDX_W-1:0]        head_b;

   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;
   logic [1:0]              inc;
   logic [COUNT_BITS:0]     sum;
   logic [COUNT_BITS-1:0]   sat_sum;
   logic [RSP_DATA_W-1:0]   rd_count;

   assign head_kind = cmd_kind_type'(q_data[0]);
   assign head_pal  = q_data[1];
   assign head_a    = q_data[2 +: IDX_W];
   assign head_b    = q_data[2+IDX_W +: IDX_W];

   assign inc     = ((state_ff == S_FIRST) && pal_ff) ? 2'd2 : 2'd1;
   assign sum     = {1'b0, rd_data_ff} + (COUNT_BITS + 1)'(inc);
   assign sat_sum = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

   generate
      if (COUNT_BITS > RSP_DATA_W) begin : g_wide
         assign rd_count = (|rd_data_ff[COUNT_BITS-1:RSP_DATA_W]) ? '1
                                                               : rd_data_ff[RSP_DATA_W-1:0];
      end else begin : g_narrow
         assign rd_count = RSP_DATA_W'(rd_data_ff);
      end
   endgenerate

   always_comb begin
      q_pop   = 1'b0;
      rd_addr = head_a;
      wr_en   = 1'b0;
      wr_addr = addr_a_ff;
      wr_data = sat_sum;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         S_IDLE: begin
            q_pop = q_valid && ((head_kind == CMD_BUMP) || !rsp_valid_ff || rsp_tready);
         end
         S_FIRST: begin
            rd_addr = addr_b_ff;
            wr_en   = (kind_ff == CMD_BUMP);
         end
         S_SECOND: begin
            wr_en   = 1'b1;
            wr_addr = addr_b_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // A read that meets a write to the same entry is never used: the reverse strand is read only
   // while the forward entry is written, and a palindrome takes a single update.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= count_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  kind_ff   <= head_kind;
                  pal_ff    <= head_pal;
                  addr_a_ff <= head_a;
                  addr_b_ff <= head_b;
                  state_ff  <= S_FIRST;
               end
            end
            S_FIRST: begin
               if (kind_ff == CMD_READ) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rd_count;
                  state_ff     <= S_IDLE;
               end else if (pal_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_SECOND;
               end
            end
            S_SECOND: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### hdl/kmer_count_both_strands_core.sv
// Top level of the k-mer counter that counts both DNA strands.
//
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata: base, query_kmer; tuser: opcode, seq_start
// rsp      out        rsp_tvalid/rsp_tready   tdata: kmer_count
// csr      in         csr_valid/csr_ready     csr_data: kmer_length
//
// A counted base passes the states S_IDLE, S_FIRST and S_SECOND of the single count memory;
// a palindrome and a read skip S_SECOND, and a base that counts nothing is not queued.
// After reset the count memory is cleared entry by entry over all 4^MAX_KMER entries (65536 by default),
// during which req_tready stays low; csr words are taken at all times.
// A four-word command queue lets requests be taken while the memory is busy; a waiting
// result holds the back part once the next read reaches the head of the queue.
`timescale 1ns / 1ps
`default_nettype none
module kmer_count_both_strands_core
   import kcbs_pkg::*;
#(
   parameter int MAX_KMER   = MAX_KMER_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_W-1:0]    req_tdata,  // base[1:0], query_kmer[17:2], zeros
   input  wire logic [REQ_USER_W-1:0]    req_tuser,  // opcode[0], seq_start[1]
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]         rsp_tdata,  // kmer_count[31:0]
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [KMER_LENGTH_W-1:0] csr_data
);

   localparam int ENTRY_W = 2 * 2 * MAX_KMER + 2;

   logic               clearing;
   logic               q_push;
   logic [ENTRY_W-1:0] q_push_data;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   logic [ENTRY_W-1:0] q_head;

   kcbs_front #(
      .MAX_KMER (MAX_KMER)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   kcbs_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   kcbs_back #(
      .MAX_KMER   (MAX_KMER),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### hdl/kcbs_checker.sv
// Port-level checks for the k-mer counting core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_count_both_strands_core_defines.svh"
module kcbs_checker
   import kcbs_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_W-1:0]    rsp_tdata
);

   // No result may appear straight out of reset.
   `KCBS_ASSERT_NEXT_ALWAYS(a_no_rsp_after_reset, clock, reset, !rsp_tvalid)

   // The count memory is being cleared after reset, so no request is taken.
   `KCBS_ASSERT_NEXT_ALWAYS(a_no_req_after_reset, clock, reset, !req_tready)

   // A result that waits keeps its value.
   `KCBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind kmer_count_both_strands_core kcbs_checker u_kcbs_checker (.*);
`default_nettype wire
